### sv/dfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_pkg
// shared types and codes of the delimited field extractor
// ----------------------------------------------------------------------------
package dfe_pkg;

	typedef enum logic [1:0] {
		CFG_DELIM_BYTES  = 2'd0,
		CFG_DELIM_LEN    = 2'd1,
		CFG_FIELD_SELECT = 2'd2,
		CFG_MAX_CHARS    = 2'd3
	} cfg_index_t;

	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_DONE   = 2'd1;
	localparam logic [1:0] KIND_ABSENT = 2'd2;

	localparam logic [31:0] DELIM_RESET  = 32'd44;
	localparam logic [2:0]  DLEN_RESET   = 3'd1;
	localparam logic [12:0] MAXCH_RESET  = 13'd256;
	localparam logic [15:0] COUNT_TOP    = 16'hFFFF;
	localparam int          MAXCH_LIMIT  = 8191;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [1:0]  kind;
		logic [12:0] copied_len;
		logic [15:0] field_total;
		logic        last;
	} result_t;

endpackage

### sv/delimited_field_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_field_extractor
// streaming extraction of one delimited field from a line of text
// ----------------------------------------------------------------------------
// One text byte or end-of-line marker is taken per cycle unless in_stall is
// high. Delimiter matching, the hold window and the counters are updated in the
// cycle of the transfer, and its results enter a result queue of twice the hold
// depth (hold depth is DELIM_MAX, up to four), rounded up to a power of two,
// so eight entries by default. A byte causes at most one result unless the
// delimiter has just been shortened while bytes are held, so text runs at one
// byte per clock if not stalled; an end of line causes up to four results
// (released held bytes and the status), which leave the queue at one per cycle
// if not stalled. Input stall rises while the queue has fewer free entries than
// the largest burst one transfer can write. No clearing pass follows reset.
module delimited_field_extractor #(
	parameter int DELIM_MAX = 4,
	parameter int LEN_MAX   = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        end_line,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [1:0]  kind,
	output logic [12:0] copied_len,
	output logic [15:0] field_total,
	output logic        last
);
	import dfe_pkg::*;

	localparam int HOLD_DEPTH = (DELIM_MAX < 4) ? DELIM_MAX : 4;
	localparam int LEN_LIMIT  = (LEN_MAX > MAXCH_LIMIT) ? MAXCH_LIMIT : LEN_MAX;
	localparam int QDEPTH     = 2 ** $clog2(2 * HOLD_DEPTH);
	localparam int NW         = $clog2(HOLD_DEPTH + 1);

	logic          fire;
	result_t       res [HOLD_DEPTH];
	logic [NW-1:0] res_count;
	result_t       head;

	assign fire = in_valid && !in_stall;

	dfe_core #(
		.HOLD_DEPTH (HOLD_DEPTH),
		.LEN_LIMIT  (LEN_LIMIT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.text_byte (text_byte),
		.end_line  (end_line),
		.res       (res),
		.res_count (res_count)
	);

	dfe_outq #(
		.WR_MAX (HOLD_DEPTH),
		.DEPTH  (QDEPTH)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fire),
		.wr_count (res_count),
		.wr_data  (res),
		.low_room (in_stall),
		.rd_valid (out_valid),
		.rd_stall (out_stall),
		.rd_data  (head)
	);

	assign out_byte    = head.out_byte;
	assign kind        = head.kind;
	assign copied_len  = head.copied_len;
	assign field_total = head.field_total;
	assign last        = head.last;

endmodule

### sv/dfe_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_core
// configuration registers, hold window and field counters; works out the
// results of one transfer in a single pass
// ----------------------------------------------------------------------------
module dfe_core #(
	parameter int HOLD_DEPTH = 4,
	parameter int LEN_LIMIT  = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_wdata,
	input  logic                 fire,
	input  logic [7:0]           text_byte,
	input  logic                 end_line,
	output dfe_pkg::result_t     res [HOLD_DEPTH],
	output logic [$clog2(HOLD_DEPTH+1)-1:0] res_count
);
	import dfe_pkg::*;

	localparam int NW = $clog2(HOLD_DEPTH + 1);
	localparam int CW = $clog2(LEN_LIMIT + 1);

	logic [31:0]   delim_bytes_q;
	logic [2:0]    delim_len_q;
	logic [15:0]   field_select_q;
	logic [12:0]   max_chars_q;

	logic [7:0]    hold_q [HOLD_DEPTH];
	logic [NW-1:0] hold_cnt_q;
	logic [15:0]   field_cnt_q;
	logic [CW-1:0] copy_cnt_q;

	logic [7:0]    seq [8];
	logic [2:0]    d, cap, cnt, pre, rem, m, e, keep;
	logic          match, sel;
	logic [CW-1:0] eff_max, limit, room, copy_nxt;
	logic [15:0]   total;
	logic          present;

	always_comb begin
		d = (delim_len_q > 3'(HOLD_DEPTH)) ? 3'(HOLD_DEPTH) : delim_len_q;
		cap = (d == 3'd0) ? 3'd0 : d - 3'd1;
		cnt = 3'(hold_cnt_q);
		pre = (cnt > cap) ? cnt - cap : 3'd0;
		rem = cnt - pre;
		for (int i = 0; i < 8; i++) begin
			if (3'(i) < cnt && i < HOLD_DEPTH) begin
				seq[i] = hold_q[i];
			end else if (3'(i) == cnt) begin
				seq[i] = text_byte;
			end else begin
				seq[i] = 8'd0;
			end
		end
		match = (d != 3'd0) && (rem == cap);
		for (int i = 0; i < HOLD_DEPTH; i++) begin
			if (3'(i) <= cap && seq[pre + 3'(i)] != delim_bytes_q[8*i +: 8]) begin
				match = 1'b0;
			end
		end
		if (end_line) begin
			m = cnt;
		end else if (d == 3'd0) begin
			m = cnt + 3'd1;
		end else begin
			m = pre + 3'((rem == cap) && !match);
		end
		keep = (end_line || d == 3'd0 || match) ? 3'd0 : cnt + 3'd1 - m;

		if (max_chars_q == 13'd0) begin
			eff_max = CW'(1);
		end else if (max_chars_q > 13'(LEN_LIMIT)) begin
			eff_max = CW'(LEN_LIMIT);
		end else begin
			eff_max = CW'(max_chars_q);
		end
		limit = eff_max - CW'(d != 3'd0);
		room = (limit > copy_cnt_q) ? limit - copy_cnt_q : '0;
		sel = (d == 3'd0) || (field_cnt_q == field_select_q);
		if (!sel) begin
			e = 3'd0;
		end else if (16'(room) < 16'(m)) begin
			e = 3'(room);
		end else begin
			e = m;
		end
		copy_nxt = copy_cnt_q + CW'(e);

		total = (field_cnt_q < COUNT_TOP) ? field_cnt_q + 16'd1 : COUNT_TOP;
		present = field_cnt_q >= field_select_q;

		for (int k = 0; k < HOLD_DEPTH; k++) begin
			res[k] = '0;
			if (3'(k) < e) begin
				res[k].out_byte = seq[k];
				res[k].kind = KIND_BYTE;
			end else if (3'(k) == e) begin
				res[k].last = 1'b1;
				if (d == 3'd0) begin
					res[k].kind = KIND_DONE;
					res[k].copied_len = 13'(copy_nxt);
					res[k].field_total = 16'd1;
				end else begin
					res[k].kind = present ? KIND_DONE : KIND_ABSENT;
					res[k].copied_len = present ? 13'(copy_nxt) : 13'd0;
					res[k].field_total = total;
				end
			end
		end
		res_count = NW'(e) + NW'(end_line);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_bytes_q  <= DELIM_RESET;
			delim_len_q    <= DLEN_RESET;
			field_select_q <= 16'd0;
			max_chars_q    <= MAXCH_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_DELIM_BYTES:  delim_bytes_q  <= cfg_wdata;
				CFG_DELIM_LEN:    delim_len_q    <= cfg_wdata[2:0];
				CFG_FIELD_SELECT: field_select_q <= cfg_wdata[15:0];
				CFG_MAX_CHARS:    max_chars_q    <= cfg_wdata[12:0];
				default:          delim_len_q    <= delim_len_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt_q  <= '0;
			field_cnt_q <= '0;
			copy_cnt_q  <= '0;
		end else if (fire) begin
			hold_cnt_q <= NW'(keep);
			if (end_line) begin
				field_cnt_q <= '0;
				copy_cnt_q  <= '0;
			end else begin
				copy_cnt_q <= copy_nxt;
				if (match && field_cnt_q < COUNT_TOP) begin
					field_cnt_q <= field_cnt_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < HOLD_DEPTH; i++) begin
				hold_q[i] <= seq[3'(i) + m];
			end
		end
	end

endmodule

### sv/dfe_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_outq
// result queue taking a burst of results per transfer, one out per cycle unless stalled
// ----------------------------------------------------------------------------
module dfe_outq #(
	parameter int WR_MAX = 4,
	parameter int DEPTH  = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [$clog2(WR_MAX+1)-1:0]   wr_count,
	input  dfe_pkg::result_t              wr_data [WR_MAX],
	output logic                          low_room,
	output logic                          rd_valid,
	input  logic                          rd_stall,
	output dfe_pkg::result_t              rd_data
);
	import dfe_pkg::*;

	localparam int PW = $clog2(DEPTH);

	result_t       mem [DEPTH];
	logic [PW-1:0] head_q, tail_q;
	logic [PW:0]   count_q;
	logic          pop;
	logic [PW:0]   wr_num;

	assign rd_valid = count_q != '0;
	assign rd_data  = mem[head_q];
	assign pop      = rd_valid && !rd_stall;
	assign wr_num   = wr_en ? (PW+1)'(wr_count) : '0;
	assign low_room = count_q > (PW+1)'(DEPTH - WR_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_q + PW'(pop);
			tail_q  <= tail_q + PW'(wr_num);
			count_q <= count_q + wr_num - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < WR_MAX; k++) begin
			if (wr_en && (PW+1)'(k) < wr_num) begin
				mem[tail_q + PW'(k)] <= wr_data[k];
			end
		end
	end

endmodule

### sv/dfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfe_checker
// port-level checks on the result channel of the field extractor
// ----------------------------------------------------------------------------
module dfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic [1:0]  kind,
	input logic [12:0] copied_len,
	input logic [15:0] field_total,
	input logic        last
);
	import dfe_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid &&
		$stable({out_byte, kind, copied_len, field_total, last}))
		else $error("stalled result changed");

	a_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_BYTE |->
		!last && copied_len == 13'd0 && field_total == 16'd0)
		else $error("byte result carries status");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |->
		(kind == KIND_DONE || kind == KIND_ABSENT) && field_total != 16'd0)
		else $error("bad end of line status");

	a_absent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ABSENT |-> copied_len == 13'd0 && last)
		else $error("absent field with length");

endmodule

bind delimited_field_extractor dfe_checker u_dfe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_byte    (out_byte),
	.kind        (kind),
	.copied_len  (copied_len),
	.field_total (field_total),
	.last        (last)
);
